// File: rtl/core/s2efir_pkg.sv
// shared constants, types and output rounding for the stereo to eight channel fir bank
// no dependencies
package s2efir_pkg;

  localparam int TAPS    = 1024;
  localparam int FILTERS = 7;
  localparam int AW      = $clog2(TAPS);
  localparam int TW      = 24;
  localparam int SW      = 32;
  localparam int XW      = SW + 1;
  localparam int PW      = TW + XW;
  localparam int ACC_W   = PW + AW;

  localparam logic [1:0] SRC_LEFT  = 2'd0;
  localparam logic [1:0] SRC_RIGHT = 2'd1;
  localparam logic [1:0] SRC_SUM   = 2'd2;

  localparam logic OP_TAP    = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [SW-1:0]    smp_t;

  typedef struct packed {
    logic          clr;
    logic          mul;
    logic          acc;
    logic          rd;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [TW-1:0] wdata;
  } lane_ctl_t;

  function automatic logic [1:0] lane_source(input logic [2:0] lane);
    unique case (lane)
      3'd0, 3'd2, 3'd4: lane_source = SRC_LEFT;
      3'd1, 3'd3, 3'd5: lane_source = SRC_RIGHT;
      default:          lane_source = SRC_SUM;
    endcase
  endfunction

  // divide toward zero by 2^23 or 2^24, then saturate to int32
  function automatic smp_t finish(input acc_t a, input logic center);
    acc_t sh;
    logic frac;
    acc_t hi;
    acc_t lo;
    hi = acc_t'(32'sh7fffffff);
    lo = -acc_t'(64'sh80000000);
    sh   = center ? (a >>> 24) : (a >>> 23);
    frac = center ? (|a[23:0]) : (|a[22:0]);
    if (a[ACC_W-1] && frac) begin
      sh = sh + acc_t'(1);
    end
    if (sh > hi) begin
      finish = 32'sh7fffffff;
    end else if (sh < lo) begin
      finish = 32'sh80000000;
    end else begin
      finish = sh[SW-1:0];
    end
  endfunction

endpackage

// File: rtl/core/stereo_to_eight_channel_fir_bank_unit.sv
// top level of the stereo to eight channel fir bank: sequencer, sample history, lanes, merge
// depends on s2efir_pkg, s2efir_lane, s2efir_merge
//
// channel | handshake          | payload
// in      | in_valid_i/stall_o | opcode, filter_select, tap_index, tap_value, samples
// out     | out_valid_o/stall_i| eight 32-bit channels
//
// a tap write is taken while idle; a sample pair is filtered in one pass over all TAPS
// entries, as the single read port of the history and tap memories is walked once per sample
// after reset a clearing pass over all TAPS entries zeroes taps and history; input is stalled
// input is stalled while a sample is being filtered; a finished frame waits in the
// output register while the next item is taken
module stereo_to_eight_channel_fir_bank_unit
  import s2efir_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                opcode_i,
  input  logic [2:0]          filter_select_i,
  input  logic [9:0]          tap_index_i,
  input  logic signed [23:0]  tap_value_i,
  input  logic signed [31:0]  left_sample_i,
  input  logic signed [31:0]  right_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  front_left_out_o,
  output logic signed [31:0]  front_right_out_o,
  output logic signed [31:0]  low_freq_out_o,
  output logic signed [31:0]  center_out_o,
  output logic signed [31:0]  side_left_out_o,
  output logic signed [31:0]  side_right_out_o,
  output logic signed [31:0]  back_left_out_o,
  output logic signed [31:0]  back_right_out_o
);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          dat_v_q, prod_v_q, out_valid_q;
  logic          in_acc, tap_wr, smp_acc, issue, last, load, tap_ok;
  smp_t          left_hist [TAPS];
  smp_t          right_hist [TAPS];
  smp_t          left_q, right_q;
  logic          h_we;
  logic [AW-1:0] h_waddr;
  smp_t          h_left, h_right;
  acc_t          accs [FILTERS];
  smp_t          chans [8];
  lane_ctl_t     ctl [FILTERS];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tap_ok     = (filter_select_i < 3'(FILTERS)) && (int'(tap_index_i) < TAPS);
  assign tap_wr     = in_acc && (opcode_i == OP_TAP) && tap_ok;
  assign smp_acc    = in_acc && (opcode_i == OP_SAMPLE);
  assign issue      = (state_q == ST_RUN);
  assign last       = (cnt_q == AW'(TAPS - 1));
  assign load       = (state_q == ST_FIN) && !(out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    unique case (state_q)
      ST_CLR: begin
        cnt_d = cnt_q + AW'(1);
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (smp_acc) begin
          ptr_d   = ptr_q + AW'(1);
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + AW'(1);
        if (last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!dat_v_q && !prod_v_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      ptr_q       <= '0;
      dat_v_q     <= 1'b0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      dat_v_q  <= issue;
      prod_v_q <= dat_v_q;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // history write: clearing pass or new sample
  always_comb begin
    h_we    = (state_q == ST_CLR) || smp_acc;
    h_waddr = (state_q == ST_CLR) ? cnt_q : ptr_d;
    h_left  = (state_q == ST_CLR) ? '0 : left_sample_i;
    h_right = (state_q == ST_CLR) ? '0 : right_sample_i;
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      left_hist[h_waddr]  <= h_left;
      right_hist[h_waddr] <= h_right;
    end
    if (issue) begin
      left_q  <= left_hist[ptr_q - cnt_q];
      right_q <= right_hist[ptr_q - cnt_q];
    end
  end

  for (genvar g = 0; g < FILTERS; g++) begin : g_lane
    always_comb begin
      ctl[g].clr   = smp_acc;
      ctl[g].rd    = issue;
      ctl[g].raddr = cnt_q;
      ctl[g].mul   = dat_v_q;
      ctl[g].acc   = prod_v_q;
      ctl[g].we    = (state_q == ST_CLR) || (tap_wr && (filter_select_i == 3'(g)));
      ctl[g].waddr = (state_q == ST_CLR) ? cnt_q : AW'(tap_index_i);
      ctl[g].wdata = (state_q == ST_CLR) ? '0 : tap_value_i;
    end

    s2efir_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .lane_id_i (3'(g)),
      .ctl_i     (ctl[g]),
      .left_i    (left_q),
      .right_i   (right_q),
      .acc_o     (accs[g])
    );
  end

  s2efir_merge u_merge (
    .clk_i  (clk_i),
    .load_i (load),
    .acc_i  (accs),
    .chan_o (chans)
  );

  assign out_valid_o       = out_valid_q;
  assign front_left_out_o  = chans[0];
  assign front_right_out_o = chans[1];
  assign low_freq_out_o    = chans[2];
  assign center_out_o      = chans[3];
  assign side_left_out_o   = chans[4];
  assign side_right_out_o  = chans[5];
  assign back_left_out_o   = chans[6];
  assign back_right_out_o  = chans[7];

  a_prod_follows_dat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_v_q |-> $past(dat_v_q))
    else $error("product valid without read data");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> (ptr_q == $past(ptr_q) + AW'(1)))
    else $error("history pointer did not advance");

endmodule

// File: rtl/core/s2efir_lane.sv
// one filter lane: tap memory, multiplier and accumulator
// depends on s2efir_pkg
module s2efir_lane
  import s2efir_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [2:0]      lane_id_i,
  input  lane_ctl_t       ctl_i,
  input  smp_t            left_i,
  input  smp_t            right_i,
  output acc_t            acc_o
);

  logic [TW-1:0]          taps [TAPS];
  logic signed [TW-1:0]   tap_q;
  logic signed [XW-1:0]   x;
  logic signed [PW-1:0]   prod_q;
  acc_t                   acc_q;
  logic [1:0]             src;

  assign src = lane_source(lane_id_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      taps[ctl_i.waddr] <= ctl_i.wdata;
    end
    if (ctl_i.rd) begin
      tap_q <= taps[ctl_i.raddr];
    end
  end

  always_comb begin
    unique case (src)
      SRC_LEFT:  x = XW'(left_i);
      SRC_RIGHT: x = XW'(right_i);
      default:   x = XW'(left_i) + XW'(right_i);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= PW'(tap_q) * PW'(x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule

// File: rtl/core/s2efir_merge.sv
// merging stage: rounds and saturates the seven lane sums into seven of the eight channel result registers
// depends on s2efir_pkg
module s2efir_merge
  import s2efir_pkg::*;
(
  input  logic  clk_i,
  input  logic  load_i,
  input  acc_t  acc_i [FILTERS],
  output smp_t  chan_o [8]
);

  smp_t chan_q [8];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chan_q[0] <= finish(acc_i[0], 1'b0);
      chan_q[1] <= finish(acc_i[1], 1'b0);
      chan_q[2] <= '0;
      chan_q[3] <= finish(acc_i[6], 1'b1);
      chan_q[4] <= finish(acc_i[2], 1'b0);
      chan_q[5] <= finish(acc_i[3], 1'b0);
      chan_q[6] <= finish(acc_i[4], 1'b0);
      chan_q[7] <= finish(acc_i[5], 1'b0);
    end
  end

  assign chan_o = chan_q;

endmodule
